// File: src/rgi_pkg.sv
// Shared widths, register index codes and configuration limits of the reorg gather index generator.
package rgi_pkg;

	// Field widths of a request and a response
	localparam int BATCH_W = 4;
	localparam int CHAN_W  = 10;
	localparam int ROW_W   = 8;
	localparam int COL_W   = 8;
	localparam int IDX_W   = 30;

	// Configuration register widths
	localparam int BCNT_W   = 5;
	localparam int CCNT_W   = 11;
	localparam int RCNT_W   = 9;
	localparam int WCNT_W   = 9;
	localparam int STRIDE_W = 5;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REORG_STRIDE  = 3'd4;

	// Legal limits of the configuration
	localparam int MAX_BATCH    = 16;
	localparam int MAX_CHANNELS = 1024;
	localparam int MAX_ROWS     = 256;
	localparam int MAX_COLS     = 256;
	localparam int STRIDE_LIMIT = 16;

endpackage

// File: src/rgi_ifs.sv
// Request and response channel interfaces of the reorg gather index generator.
interface rgi_req_if;
	logic                        valid;
	logic                        ready;
	logic [rgi_pkg::BATCH_W-1:0] batch_index;
	logic [rgi_pkg::CHAN_W-1:0]  chan_index;
	logic [rgi_pkg::ROW_W-1:0]   row_index;
	logic [rgi_pkg::COL_W-1:0]   col_index;

	modport source (output valid, batch_index, chan_index, row_index, col_index, input ready);
	modport sink (input valid, batch_index, chan_index, row_index, col_index, output ready);
endinterface

interface rgi_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [rgi_pkg::IDX_W-1:0] dest_flat;
	logic [rgi_pkg::IDX_W-1:0] source_flat;
	logic                      bad_request;

	modport source (output valid, dest_flat, source_flat, bad_request, input ready);
	modport sink (input valid, dest_flat, source_flat, bad_request, output ready);
endinterface

// File: src/reorg_gather_index_core.sv
// Top level of the reorg gather index generator: config, derived terms and index pipeline.
//
// Usage
//   req carries one destination coordinate (batch, channel, row, column) per
//   transaction; rsp returns the flat destination index, the flat source index
//   to gather from, and bad_request. Both are valid/ready channels.
//   The config port writes one register per cycle with cfg_we high.
// Throughput
//   One request transaction per cycle is taken in steady state while rsp is
//   not stalled and no derivation pass runs. The seven-stage pipeline
//   holds two pipelined divider stages for c / q and one for k / s.
// Configuration
//   Every write, and reset, starts a derivation pass: a bit-serial divider
//   forms q = channel_count / stride^2 and the remainder check, then q and
//   the scaled source extents are latched. req.ready stays low during the
//   pass. Config writes are taken at any time.
// Reset and stall
//   Reset returns the registers to their defaults, empties the pipeline and
//   runs the derivation pass. A stalled rsp freezes all stages; nothing is
//   dropped or repeated, and req.ready falls while the output is held.
module reorg_gather_index_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rgi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rgi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	rgi_req_if.sink                          req,
	rgi_rsp_if.source                        rsp
);

	localparam int IW = rgi_pkg::IDX_W;
	localparam int QW = rgi_pkg::CCNT_W;                 // quotient q and its remainders
	localparam int SW = rgi_pkg::STRIDE_W;
	localparam int SQW = 2 * SW;                         // stride squared
	localparam int HSW = rgi_pkg::RCNT_W + SW;           // scaled extents
	localparam int CNTW = 4;
	localparam logic [CNTW-1:0] DIV_LAST = CNTW'(rgi_pkg::CCNT_W - 1);
	localparam int HALF = rgi_pkg::CHAN_W / 2;
	localparam int KW = 8;                               // sub-pixel offset bits used

	typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_DONE} cfg_state_t;

	// ---------------- configuration registers ----------------
	logic [rgi_pkg::BCNT_W-1:0]   batch_count_q;
	logic [rgi_pkg::CCNT_W-1:0]   channel_count_q;
	logic [rgi_pkg::RCNT_W-1:0]   row_count_q;
	logic [rgi_pkg::WCNT_W-1:0]   col_count_q;
	logic [SW-1:0]                reorg_stride_q;

	// Store register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_count_q   <= 5'd1;
			channel_count_q <= 11'd4;
			row_count_q     <= 9'd1;
			col_count_q     <= 9'd1;
			reorg_stride_q  <= 5'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rgi_pkg::REG_BATCH_COUNT:   batch_count_q   <= cfg_wdata[rgi_pkg::BCNT_W-1:0];
				rgi_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_wdata[rgi_pkg::CCNT_W-1:0];
				rgi_pkg::REG_ROW_COUNT:     row_count_q     <= cfg_wdata[rgi_pkg::RCNT_W-1:0];
				rgi_pkg::REG_COL_COUNT:     col_count_q     <= cfg_wdata[rgi_pkg::WCNT_W-1:0];
				rgi_pkg::REG_REORG_STRIDE:  reorg_stride_q  <= cfg_wdata[SW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- derivation pass ----------------
	cfg_state_t          cfg_state_q;
	logic [SQW-1:0]      div_den_q;
	logic [SQW-1:0]      div_rem_q;
	logic [QW-1:0]       div_quo_q;
	logic [CNTW-1:0]     div_cnt_q;
	logic [QW-1:0]       q_q;
	logic [HSW-1:0]      rows_src_q;
	logic [HSW-1:0]      cols_src_q;
	logic                cfg_ok_q;

	logic [SQW-1:0]      sq_w;
	logic [SQW:0]        div_trial;
	logic                div_take;
	logic                counts_ok;

	assign sq_w      = SQW'(reorg_stride_q) * SQW'(reorg_stride_q);
	assign div_trial = {div_rem_q, div_quo_q[QW-1]};
	assign div_take  = div_trial >= {1'b0, div_den_q};
	assign counts_ok =
		(batch_count_q != '0) && (int'(batch_count_q) <= rgi_pkg::MAX_BATCH) &&
		(channel_count_q != '0) && (int'(channel_count_q) <= rgi_pkg::MAX_CHANNELS) &&
		(row_count_q != '0) && (int'(row_count_q) <= rgi_pkg::MAX_ROWS) &&
		(col_count_q != '0) && (int'(col_count_q) <= rgi_pkg::MAX_COLS) &&
		(reorg_stride_q != '0) && (int'(reorg_stride_q) <= rgi_pkg::STRIDE_LIMIT);

	// Divide channel_count by stride^2 one bit a cycle, then latch derived terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_state_q <= ST_LOAD;
			div_den_q   <= '0;
			div_rem_q   <= '0;
			div_quo_q   <= '0;
			div_cnt_q   <= '0;
			q_q         <= '0;
			rows_src_q  <= '0;
			cols_src_q  <= '0;
			cfg_ok_q    <= 1'b0;
		end else if (cfg_we) begin
			cfg_state_q <= ST_LOAD;
		end else begin
			unique case (cfg_state_q)
				ST_IDLE: ;
				ST_LOAD: begin
					div_den_q   <= sq_w;
					div_rem_q   <= '0;
					div_quo_q   <= channel_count_q;
					div_cnt_q   <= '0;
					cfg_state_q <= ST_DIV;
				end
				ST_DIV: begin
					div_rem_q <= div_take ? SQW'(div_trial - {1'b0, div_den_q})
						: div_trial[SQW-1:0];
					div_quo_q <= {div_quo_q[QW-2:0], div_take};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						cfg_state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					q_q         <= div_quo_q;
					rows_src_q  <= HSW'(row_count_q) * HSW'(reorg_stride_q);
					cols_src_q  <= HSW'(col_count_q) * HSW'(reorg_stride_q);
					cfg_ok_q    <= counts_ok && (div_rem_q == '0) && (div_quo_q != '0);
					cfg_state_q <= ST_IDLE;
				end
				default: cfg_state_q <= ST_LOAD;
			endcase
		end
	end

	// ---------------- index pipeline ----------------
	logic adv;
	logic take;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	assign adv       = !v_s7 || rsp.ready;
	assign req.ready = adv && (cfg_state_q == ST_IDLE);
	assign take      = req.valid && req.ready;

	// Advance valid bits together with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: range check, b*C, upper half of c / q
	logic [rgi_pkg::BATCH_W-1:0] b_s1;
	logic [rgi_pkg::CHAN_W-1:0]  c_s1;
	logic [rgi_pkg::ROW_W-1:0]   r_s1, r_s2, r_s3;
	logic [rgi_pkg::COL_W-1:0]   w_s1, w_s2, w_s3, w_s4, w_s5;
	logic                        bad_s1, bad_s2, bad_s3, bad_s4, bad_s5, bad_s6;
	logic [15:0]                 bc_s1;
	logic [QW-1:0]               rem_s1;
	logic [HALF-1:0]             qhi_s1;

	logic [QW-1:0]   hi_rem;
	logic [HALF-1:0] hi_quo;
	logic [QW:0]     hi_trial;
	logic            bad_in;

	always_comb begin
		hi_rem   = '0;
		hi_quo   = '0;
		hi_trial = '0;
		for (int i = 0; i < HALF; i++) begin
			hi_trial = {hi_rem, req.chan_index[rgi_pkg::CHAN_W-1-i]};
			if (hi_trial >= {1'b0, q_q}) begin
				hi_rem = QW'(hi_trial - {1'b0, q_q});
				hi_quo[HALF-1-i] = 1'b1;
			end else begin
				hi_rem = hi_trial[QW-1:0];
			end
		end
	end

	assign bad_in = !cfg_ok_q ||
		({1'b0, req.batch_index} >= batch_count_q) ||
		({1'b0, req.chan_index} >= channel_count_q) ||
		({1'b0, req.row_index} >= row_count_q) ||
		({1'b0, req.col_index} >= col_count_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s1   <= req.batch_index;
			c_s1   <= req.chan_index;
			r_s1   <= req.row_index;
			w_s1   <= req.col_index;
			bad_s1 <= bad_in;
			bc_s1  <= 16'(req.batch_index) * 16'(channel_count_q);
			rem_s1 <= hi_rem;
			qhi_s1 <= hi_quo;
		end
	end

	// Stage 2: lower half of c / q, b*C + c, b*q
	logic [rgi_pkg::CHAN_W-1:0] k_s2;
	logic [QW-1:0]              srcc_s2;
	logic [15:0]                d1_s2;
	logic [15:0]                bq_s2;

	logic [QW-1:0]   lo_rem;
	logic [HALF-1:0] lo_quo;
	logic [QW:0]     lo_trial;

	always_comb begin
		lo_rem   = rem_s1;
		lo_quo   = '0;
		lo_trial = '0;
		for (int i = 0; i < HALF; i++) begin
			lo_trial = {lo_rem, c_s1[HALF-1-i]};
			if (lo_trial >= {1'b0, q_q}) begin
				lo_rem = QW'(lo_trial - {1'b0, q_q});
				lo_quo[HALF-1-i] = 1'b1;
			end else begin
				lo_rem = lo_trial[QW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s2    <= {qhi_s1, lo_quo};
			srcc_s2 <= lo_rem;
			d1_s2   <= 16'(bc_s1) + 16'(c_s1);
			bq_s2   <= 16'(b_s1) * 16'(q_q);
			r_s2    <= r_s1;
			w_s2    <= w_s1;
			bad_s2  <= bad_s1;
		end
	end

	// Stage 3: split k into row and column offsets, (b*C+c)*H, b*q + c mod q
	logic [KW-1:0] ky_s3;
	logic [SW-1:0] kx_s3;
	logic [24:0]   d2_s3;
	logic [15:0]   sc1_s3;

	logic [SW-1:0] k_rem;
	logic [KW-1:0] k_quo;
	logic [SW:0]   k_trial;

	always_comb begin
		k_rem   = '0;
		k_quo   = '0;
		k_trial = '0;
		for (int i = 0; i < KW; i++) begin
			k_trial = {k_rem, k_s2[KW-1-i]};
			if (k_trial >= {1'b0, reorg_stride_q}) begin
				k_rem = SW'(k_trial - {1'b0, reorg_stride_q});
				k_quo[KW-1-i] = 1'b1;
			end else begin
				k_rem = k_trial[SW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ky_s3  <= k_quo;
			kx_s3  <= k_rem;
			d2_s3  <= 25'(d1_s2) * 25'(row_count_q);
			sc1_s3 <= 16'(bq_s2) + 16'(srcc_s2);
			r_s3   <= r_s2;
			w_s3   <= w_s2;
			bad_s3 <= bad_s2;
		end
	end

	// Stage 4: + r, source row, times scaled rows
	logic [25:0]   d3_s4;
	logic [HSW-1:0] srow_s4;
	logic [IW-1:0] sc2_s4;
	logic [SW-1:0] kx_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			d3_s4   <= 26'(d2_s3) + 26'(r_s3);
			srow_s4 <= HSW'(r_s3) * HSW'(reorg_stride_q) + HSW'(ky_s3);
			sc2_s4  <= IW'(sc1_s3) * IW'(rows_src_q);
			kx_s4   <= kx_s3;
			w_s4    <= w_s3;
			bad_s4  <= bad_s3;
		end
	end

	// Stage 5: times W, + source row, source column
	logic [IW-1:0]  d4_s5;
	logic [IW-1:0]  sc3_s5;
	logic [HSW-1:0] scol_s5, scol_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			d4_s5   <= IW'(d3_s4) * IW'(col_count_q);
			sc3_s5  <= sc2_s4 + IW'(srow_s4);
			scol_s5 <= HSW'(w_s4) * HSW'(reorg_stride_q) + HSW'(kx_s4);
			w_s5    <= w_s4;
			bad_s5  <= bad_s4;
		end
	end

	// Stage 6: + w, times scaled columns
	logic [IW-1:0] d5_s6;
	logic [IW-1:0] sc4_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			d5_s6   <= d4_s5 + IW'(w_s5);
			sc4_s6  <= sc3_s5 * IW'(cols_src_q);
			scol_s6 <= scol_s5;
			bad_s6  <= bad_s5;
		end
	end

	// Stage 7: output register, zero the indices of a bad request
	logic [IW-1:0] dest_s7;
	logic [IW-1:0] src_s7;
	logic          bad_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			dest_s7 <= bad_s6 ? '0 : d5_s6;
			src_s7  <= bad_s6 ? '0 : sc4_s6 + IW'(scol_s6);
			bad_s7  <= bad_s6;
		end
	end

	assign rsp.valid       = v_s7;
	assign rsp.dest_flat   = dest_s7;
	assign rsp.source_flat = src_s7;
	assign rsp.bad_request = bad_s7;

	// ---------------- assertions ----------------
	a_cfg_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !req.ready)
		else $error("request taken right after a config write");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.bad_request |-> (rsp.dest_flat == '0) && (rsp.source_flat == '0))
		else $error("bad request carries nonzero indices");

	a_q_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_state_q == ST_IDLE) && cfg_ok_q |->
		(({10'b0, q_q} * {11'b0, sq_w}) == {10'b0, channel_count_q}))
		else $error("derived channel quotient inconsistent");

	a_cmod_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !bad_s2 |-> srcc_s2 < q_q)
		else $error("source channel remainder out of range");

	a_subpix_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !bad_s3 |-> (kx_s3 < reorg_stride_q) && (ky_s3 < {3'b0, reorg_stride_q}))
		else $error("sub-pixel offset out of range");

endmodule

// File: tb/reorg_gather_index_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the reorg gather index generator: directed and random traffic against a predictor.
module reorg_gather_index_core_tb;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int RANDOM_ITEMS     = 1100;
	localparam int SETTLE_CYCLES    = 20;
	localparam int LONG_HOLD_CYCLES = 240;
	localparam int LONG_HOLD_AFTER  = 300;

	// Indexes past the register list; writes there must leave the layer untouched
	localparam logic [rgi_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [rgi_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [rgi_pkg::BCNT_W-1:0]   batches;
		logic [rgi_pkg::CCNT_W-1:0]   channels;
		logic [rgi_pkg::RCNT_W-1:0]   rows;
		logic [rgi_pkg::WCNT_W-1:0]   cols;
		logic [rgi_pkg::STRIDE_W-1:0] stride;
	} layer_cfg_t;

	typedef struct packed {
		logic [rgi_pkg::BATCH_W-1:0] batch;
		logic [rgi_pkg::CHAN_W-1:0]  chan;
		logic [rgi_pkg::ROW_W-1:0]   row;
		logic [rgi_pkg::COL_W-1:0]   col;
	} coord_t;

	typedef struct packed {
		logic [rgi_pkg::IDX_W-1:0] dest_flat;
		logic [rgi_pkg::IDX_W-1:0] source_flat;
		logic                      bad_request;
	} gather_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [rgi_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rgi_pkg::CFG_DATA_W-1:0] cfg_wdata;

	rgi_req_if req_ch();
	rgi_rsp_if rsp_ch();

	reorg_gather_index_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	layer_cfg_t layer_cfg;
	coord_t     coords_to_send[$];
	gather_t    gathers_due[$];
	int         err_count;
	int         rsp_seen;
	int         cycle_count;
	int         gap_left;
	int         ready_low_left;
	int         long_hold_left;
	bit         req_taken;
	bit         quiet_phase;
	bit         long_hold_done;

	// Shadow of one register write, masked to the register width
	function automatic layer_cfg_t apply_reg(layer_cfg_t cfg,
			logic [rgi_pkg::CFG_IDX_W-1:0] idx, logic [rgi_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			rgi_pkg::REG_BATCH_COUNT:   cfg.batches  = val[rgi_pkg::BCNT_W-1:0];
			rgi_pkg::REG_CHANNEL_COUNT: cfg.channels = val[rgi_pkg::CCNT_W-1:0];
			rgi_pkg::REG_ROW_COUNT:     cfg.rows     = val[rgi_pkg::RCNT_W-1:0];
			rgi_pkg::REG_COL_COUNT:     cfg.cols     = val[rgi_pkg::WCNT_W-1:0];
			rgi_pkg::REG_REORG_STRIDE:  cfg.stride   = val[rgi_pkg::STRIDE_W-1:0];
			default: ;
		endcase
		return cfg;
	endfunction

	// Work out the destination and source indexes of one coordinate
	function automatic gather_t predict_gather(layer_cfg_t cfg, coord_t co);
		longint unsigned nb, nc, nh, nw, s, sq, q, k;
		longint unsigned src_row, src_col, dst, src;
		bit bad;
		gather_t res;
		nb = 64'(cfg.batches);
		nc = 64'(cfg.channels);
		nh = 64'(cfg.rows);
		nw = 64'(cfg.cols);
		s  = 64'(cfg.stride);
		sq = s * s;
		bad = nb == 0 || nb > rgi_pkg::MAX_BATCH || nc == 0 || nc > rgi_pkg::MAX_CHANNELS ||
			nh == 0 || nh > rgi_pkg::MAX_ROWS || nw == 0 || nw > rgi_pkg::MAX_COLS ||
			s == 0 || s > rgi_pkg::STRIDE_LIMIT;
		// channels must be a positive multiple of stride squared
		if (!bad)
			bad = nc < sq || (nc % sq) != 0;
		bad = bad || co.batch >= nb || co.chan >= nc || co.row >= nh || co.col >= nw;
		res = '0;
		res.bad_request = bad;
		if (!bad) begin
			q       = nc / sq;
			k       = co.chan / q;
			src_col = co.col * s + k % s;
			src_row = co.row * s + k / s;
			dst     = ((co.batch * nc + co.chan) * nh + co.row) * nw + co.col;
			src     = ((co.batch * q + co.chan % q) * (nh * s) + src_row) * (nw * s) + src_col;
			res.dest_flat   = dst[rgi_pkg::IDX_W-1:0];
			res.source_flat = src[rgi_pkg::IDX_W-1:0];
		end
		return res;
	endfunction

	function automatic int coord_limit(int count, int top);
		if (count == 0)
			return 0;
		return (count - 1 > top) ? top : count - 1;
	endfunction

	// Mostly in-range coordinates, the rest with one field or all fields thrown anywhere
	function automatic coord_t rand_coord(layer_cfg_t cfg);
		coord_t co;
		co.batch = rgi_pkg::BATCH_W'($urandom_range(0,
			coord_limit(int'(cfg.batches), (1 << rgi_pkg::BATCH_W) - 1)));
		co.chan  = rgi_pkg::CHAN_W'($urandom_range(0,
			coord_limit(int'(cfg.channels), (1 << rgi_pkg::CHAN_W) - 1)));
		co.row   = rgi_pkg::ROW_W'($urandom_range(0,
			coord_limit(int'(cfg.rows), (1 << rgi_pkg::ROW_W) - 1)));
		co.col   = rgi_pkg::COL_W'($urandom_range(0,
			coord_limit(int'(cfg.cols), (1 << rgi_pkg::COL_W) - 1)));
		if ($urandom_range(0, 99) < 15) begin
			case ($urandom_range(0, 4))
				0: co.batch = rgi_pkg::BATCH_W'($urandom);
				1: co.chan  = rgi_pkg::CHAN_W'($urandom);
				2: co.row   = rgi_pkg::ROW_W'($urandom);
				3: co.col   = rgi_pkg::COL_W'($urandom);
				default: begin
					co.batch = rgi_pkg::BATCH_W'($urandom);
					co.chan  = rgi_pkg::CHAN_W'($urandom);
					co.row   = rgi_pkg::ROW_W'($urandom);
					co.col   = rgi_pkg::COL_W'($urandom);
				end
			endcase
		end
		return co;
	endfunction

	function automatic int rand_extent(int top);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(1, 16);
		if (r < 85)
			return $urandom_range(1, top);
		return ($urandom_range(0, 1) != 0) ? top : 1;
	endfunction

	// Idle length after a request transaction
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	task automatic write_reg(logic [rgi_pkg::CFG_IDX_W-1:0] idx,
			logic [rgi_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		layer_cfg = apply_reg(layer_cfg, idx, val);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_layer(int b, int c, int h, int w, int s);
		write_reg(rgi_pkg::REG_BATCH_COUNT, rgi_pkg::CFG_DATA_W'(b));
		write_reg(rgi_pkg::REG_CHANNEL_COUNT, rgi_pkg::CFG_DATA_W'(c));
		write_reg(rgi_pkg::REG_ROW_COUNT, rgi_pkg::CFG_DATA_W'(h));
		write_reg(rgi_pkg::REG_COL_COUNT, rgi_pkg::CFG_DATA_W'(w));
		write_reg(rgi_pkg::REG_REORG_STRIDE, rgi_pkg::CFG_DATA_W'(s));
		end_writes();
	endtask

	task automatic push_coord(int b, int c, int r, int w);
		coords_to_send.push_back({rgi_pkg::BATCH_W'(b), rgi_pkg::CHAN_W'(c),
			rgi_pkg::ROW_W'(r), rgi_pkg::COL_W'(w)});
	endtask

	// Wait until every queued coordinate is sent and every result is back
	task automatic drain();
		do
			@(posedge clk);
		while (coords_to_send.size() != 0 || req_ch.valid || gathers_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Pick a legal layer most of the time, otherwise break one register or make channels no multiple of stride squared
	task automatic random_layer();
		int s, b, c, h, w;
		s = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
		c = $urandom_range(1, rgi_pkg::MAX_CHANNELS / (s * s)) * s * s;
		b = $urandom_range(1, rgi_pkg::MAX_BATCH);
		h = rand_extent(rgi_pkg::MAX_ROWS);
		w = rand_extent(rgi_pkg::MAX_COLS);
		if ($urandom_range(0, 5) == 0) begin
			case ($urandom_range(0, 5))
				0: b = ($urandom_range(0, 1) != 0) ? 0 :
					$urandom_range(rgi_pkg::MAX_BATCH + 1, 2047);
				1: c = ($urandom_range(0, 1) != 0) ? 0 :
					$urandom_range(rgi_pkg::MAX_CHANNELS + 1, 2047);
				2: begin
					s = $urandom_range(2, 4);
					c = $urandom_range(0, 8) * s * s + $urandom_range(1, s * s - 1);
				end
				3: h = ($urandom_range(0, 1) != 0) ? 0 :
					$urandom_range(rgi_pkg::MAX_ROWS + 1, 511);
				4: w = ($urandom_range(0, 1) != 0) ? 0 :
					$urandom_range(rgi_pkg::MAX_COLS + 1, 511);
				default: s = ($urandom_range(0, 1) != 0) ? 0 :
					$urandom_range(rgi_pkg::STRIDE_LIMIT + 1, 31);
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			write_reg(rgi_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
				rgi_pkg::CFG_DATA_W'($urandom));
		set_layer(b, c, h, w, s);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Check each result transaction, then predict each request transaction
	always @(posedge clk) begin : score
		gather_t want;
		coord_t  co;
		if (rsp_ch.valid && rsp_ch.ready) begin
			rsp_seen++;
			if (gathers_due.size() == 0) begin
				err_count++;
				$error("result with none pending: dest_flat %0d source_flat %0d bad_request %0b",
					rsp_ch.dest_flat, rsp_ch.source_flat, rsp_ch.bad_request);
			end else begin
				want = gathers_due.pop_front();
				if (rsp_ch.dest_flat !== want.dest_flat) begin
					err_count++;
					$error("dest_flat: expected %0d, got %0d", want.dest_flat, rsp_ch.dest_flat);
				end
				if (rsp_ch.source_flat !== want.source_flat) begin
					err_count++;
					$error("source_flat: expected %0d, got %0d",
						want.source_flat, rsp_ch.source_flat);
				end
				if (rsp_ch.bad_request !== want.bad_request) begin
					err_count++;
					$error("bad_request: expected %0b, got %0b",
						want.bad_request, rsp_ch.bad_request);
				end
			end
		end
		if (req_ch.valid && req_ch.ready) begin
			co = {req_ch.batch_index, req_ch.chan_index, req_ch.row_index, req_ch.col_index};
			gathers_due.push_back(predict_gather(layer_cfg, co));
			req_taken = 1'b1;
		end
	end

	// Offer queued coordinates, with random gaps between transactions
	always @(negedge clk) begin : drive_requests
		coord_t co;
		bit     moved;
		moved     = req_taken;
		req_taken = 1'b0;
		if (moved)
			gap_left = gap_len();
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.batch_index <= '0;
			req_ch.chan_index  <= '0;
			req_ch.row_index   <= '0;
			req_ch.col_index   <= '0;
		end else if (!req_ch.valid || moved) begin
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (coords_to_send.size() != 0) begin
				co = coords_to_send.pop_front();
				req_ch.batch_index <= co.batch;
				req_ch.chan_index  <= co.chan;
				req_ch.row_index   <= co.row;
				req_ch.col_index   <= co.col;
				req_ch.valid       <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random, once for a long stretch under load
	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (long_hold_left > 0) begin
			long_hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (!long_hold_done && rsp_seen >= LONG_HOLD_AFTER && req_ch.valid &&
				coords_to_send.size() > 16) begin
			long_hold_done = 1'b1;
			long_hold_left = LONG_HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (ready_low_left > 0) begin
			ready_low_left--;
			rsp_ch.ready <= 1'b0;
		end else if (!quiet_phase && $urandom_range(0, 99) < 20) begin
			ready_low_left = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 30) :
				$urandom_range(0, 2);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int sent;
		int n;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = rgi_pkg::REG_BATCH_COUNT;
		cfg_wdata          = '0;
		layer_cfg          = '{batches: 1, channels: 4, rows: 1, cols: 1, stride: 2};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset layer: corners and each coordinate one past its count
		push_coord(0, 0, 0, 0);
		push_coord(0, 3, 0, 0);
		push_coord(0, 4, 0, 0);
		push_coord(1, 0, 0, 0);
		push_coord(0, 0, 1, 0);
		push_coord(0, 0, 0, 1);
		push_coord(15, 1023, 255, 255);
		drain();

		// Largest layer with the largest stride
		set_layer(rgi_pkg::MAX_BATCH, rgi_pkg::MAX_CHANNELS, rgi_pkg::MAX_ROWS,
			rgi_pkg::MAX_COLS, rgi_pkg::STRIDE_LIMIT);
		push_coord(15, 1023, 255, 255);
		push_coord(0, 0, 0, 0);
		push_coord(15, 0, 255, 0);
		push_coord(0, 1023, 0, 255);
		push_coord(7, 512, 128, 64);
		drain();

		// Unit stride: source equals destination
		set_layer(rgi_pkg::MAX_BATCH, rgi_pkg::MAX_CHANNELS, rgi_pkg::MAX_ROWS,
			rgi_pkg::MAX_COLS, 1);
		push_coord(15, 1023, 255, 255);
		push_coord(3, 5, 7, 9);
		drain();

		// Writes past the register list are dropped
		for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
			write_reg(rgi_pkg::CFG_IDX_W'(i), '1);
		end_writes();
		push_coord(15, 1023, 255, 255);
		drain();

		// Inconsistent layers: channels not a multiple, zero stride, stride too big,
		// zero batches, channels below stride squared
		set_layer(1, 6, 1, 1, 2);
		push_coord(0, 0, 0, 0);
		drain();
		set_layer(1, 4, 1, 1, 0);
		push_coord(0, 0, 0, 0);
		drain();
		set_layer(1, 4, 1, 1, rgi_pkg::STRIDE_LIMIT + 1);
		push_coord(0, 0, 0, 0);
		drain();
		set_layer(0, 4, 1, 1, 2);
		push_coord(0, 0, 0, 0);
		drain();
		set_layer(1, 2, 1, 1, 2);
		push_coord(0, 0, 0, 0);
		drain();

		// Random layers, each with a burst of coordinates
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			random_layer();
			quiet_phase = ($urandom_range(0, 4) == 0);
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(8, 40);
			repeat (n) coords_to_send.push_back(rand_coord(layer_cfg));
			sent += n;
			drain();
		end
		quiet_phase = 1'b0;

		drain();
		if (err_count == 0 && gathers_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
src/rgi_pkg.sv
src/rgi_ifs.sv
src/reorg_gather_index_core.sv
tb/reorg_gather_index_core_tb.sv
